>>> hdl/hws_pkg.sv
// ----------------------------------------------------------------------------
// Heater warm-up sequencer package
// Shared constants, phase codes and the microcode control word layout.
// ----------------------------------------------------------------------------
package hws_pkg;

	// Phase codes as reported on the result port.
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_COND = 3'd1;
	localparam logic [2:0] PH_RAMP = 3'd2;
	localparam logic [2:0] PH_WAIT = 3'd3;
	localparam logic [2:0] PH_DONE = 3'd4;

	// Heater targets in tenths of a volt.
	localparam logic [7:0] COND_TENTHS       = 8'd20;
	localparam logic [7:0] RAMP_FIRST_TENTHS = 8'd85;
	localparam logic [7:0] RAMP_STEP_TENTHS  = 8'd4;
	localparam logic [8:0] RAMP_END_TENTHS   = 9'd130;

	localparam logic [3:0] CONDENSE_TICKS = 4'd5;

	// Duty = floor(tenths * NUM_K / (battery * DEN_K)), NUM_K = 255 * 4095.
	localparam int NUM_W = 28;
	localparam int DEN_W = 20;
	localparam int QUO_W = 9;
	localparam logic [NUM_W-1:0] NUM_K = 28'd1044225;
	localparam logic [DEN_W-1:0] DEN_K = 20'd183;
	localparam logic [3:0] DIV_LAST_BIT = 4'(QUO_W - 1);

	// Microcode program counter.
	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t ADDR_WAIT_REQ  = 5'd0;
	localparam pc_t ADDR_DISPATCH  = 5'd1;
	localparam pc_t ADDR_CHK_COND  = 5'd2;
	localparam pc_t ADDR_CHK_RAMP  = 5'd3;
	localparam pc_t ADDR_CHK_WAIT  = 5'd4;
	localparam pc_t ADDR_NO_CHANGE = 5'd5;
	localparam pc_t ADDR_COND_TICK = 5'd6;
	localparam pc_t ADDR_COND_TEST = 5'd7;
	localparam pc_t ADDR_RAMP_ENTR = 5'd8;
	localparam pc_t ADDR_RAMP_TEST = 5'd9;
	localparam pc_t ADDR_RAMP_STEP = 5'd10;
	localparam pc_t ADDR_SET_WAIT  = 5'd11;
	localparam pc_t ADDR_UR_TEST   = 5'd12;
	localparam pc_t ADDR_SET_DONE  = 5'd13;
	localparam pc_t ADDR_START     = 5'd14;
	localparam pc_t ADDR_MUL       = 5'd15;
	localparam pc_t ADDR_DIV       = 5'd16;
	localparam pc_t ADDR_DUTY      = 5'd17;
	localparam pc_t ADDR_EMIT      = 5'd18;
	localparam pc_t ADDR_RETURN    = 5'd19;

	// Datapath action of one microcode step.
	typedef enum logic [3:0] {
		ACT_NOP,
		ACT_LATCH,
		ACT_START,
		ACT_TICK,
		ACT_RAMP_ENTER,
		ACT_RAMP_STEP,
		ACT_SET_WAIT,
		ACT_SET_DONE,
		ACT_MUL,
		ACT_DIV,
		ACT_DUTY,
		ACT_EMIT
	} act_t;

	// Jump condition; when it holds the sequencer goes to the target,
	// otherwise to the next step.
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_REQ,
		C_START,
		C_PH_COND,
		C_PH_RAMP,
		C_PH_WAIT,
		C_TICK_LT,
		C_RAMP_END,
		C_UR_ABOVE,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   target;
	} uword_t;

endpackage

>>> hdl/hws_ucode_rom.sv
// ----------------------------------------------------------------------------
// Heater warm-up sequencer microcode ROM
// Read-only program: one control word per step, looked up by the step counter.
// ----------------------------------------------------------------------------
module hws_ucode_rom (
	input  hws_pkg::pc_t   pc,
	output hws_pkg::uword_t uword
);
	import hws_pkg::*;

	always_comb begin
		case (pc)
			ADDR_WAIT_REQ:  uword = '{ACT_LATCH,      C_NO_REQ,   ADDR_WAIT_REQ};
			ADDR_DISPATCH:  uword = '{ACT_NOP,        C_START,    ADDR_START};
			ADDR_CHK_COND:  uword = '{ACT_NOP,        C_PH_COND,  ADDR_COND_TICK};
			ADDR_CHK_RAMP:  uword = '{ACT_NOP,        C_PH_RAMP,  ADDR_RAMP_TEST};
			ADDR_CHK_WAIT:  uword = '{ACT_NOP,        C_PH_WAIT,  ADDR_UR_TEST};
			ADDR_NO_CHANGE: uword = '{ACT_NOP,        C_ALWAYS,   ADDR_EMIT};
			ADDR_COND_TICK: uword = '{ACT_TICK,       C_NEVER,    ADDR_WAIT_REQ};
			ADDR_COND_TEST: uword = '{ACT_NOP,        C_TICK_LT,  ADDR_EMIT};
			ADDR_RAMP_ENTR: uword = '{ACT_RAMP_ENTER, C_ALWAYS,   ADDR_MUL};
			ADDR_RAMP_TEST: uword = '{ACT_NOP,        C_RAMP_END, ADDR_SET_WAIT};
			ADDR_RAMP_STEP: uword = '{ACT_RAMP_STEP,  C_ALWAYS,   ADDR_MUL};
			ADDR_SET_WAIT:  uword = '{ACT_SET_WAIT,   C_NEVER,    ADDR_WAIT_REQ};
			ADDR_UR_TEST:   uword = '{ACT_NOP,        C_UR_ABOVE, ADDR_EMIT};
			ADDR_SET_DONE:  uword = '{ACT_SET_DONE,   C_ALWAYS,   ADDR_EMIT};
			ADDR_START:     uword = '{ACT_START,      C_NEVER,    ADDR_WAIT_REQ};
			ADDR_MUL:       uword = '{ACT_MUL,        C_NEVER,    ADDR_WAIT_REQ};
			ADDR_DIV:       uword = '{ACT_DIV,        C_DIV_MORE, ADDR_DIV};
			ADDR_DUTY:      uword = '{ACT_DUTY,       C_NEVER,    ADDR_WAIT_REQ};
			ADDR_EMIT:      uword = '{ACT_EMIT,       C_OUT_BUSY, ADDR_EMIT};
			ADDR_RETURN:    uword = '{ACT_NOP,        C_ALWAYS,   ADDR_WAIT_REQ};
			default:        uword = '{ACT_NOP,        C_ALWAYS,   ADDR_WAIT_REQ};
		endcase
	end

endmodule

>>> hdl/heater_warmup_sequencer.sv
// ----------------------------------------------------------------------------
// Heater warm-up sequencer
// Microcoded controller for an oxygen-sensor heater warm-up, one request per
// one-second tick or start command.
// ----------------------------------------------------------------------------
// A start request (op = 0) latches the battery sample and begins condensation
// at a 2.0 V heater target; each tick request (op = 1) advances the sequence:
// after CONDENSE_TICKS ticks the ramp starts at 8.5 V and climbs 0.4 V per
// tick up to 12.9 V, then the block waits until the sensor-resistance sample
// is at or below the configured resistance limit, drops the duty to zero and
// flags finished. Every request produces exactly one response carrying the
// applied duty, the phase after the request and the finished flag. The duty is
// floor(target * 255 * 4095 / (battery * 183)), saturated at 255, and a zero
// battery sample gives 255. A request runs through the microcode program,
// whose longest path runs through the nine-step restoring divider that forms
// the duty one quotient bit per cycle. The emit step waits while the output
// register stays full. A new request is taken once the previous response has
// been placed in the output register, even if the consumer has not yet taken
// it. The resistance limit is written through cfg_wr_en / cfg_wr_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce.
// ----------------------------------------------------------------------------
module heater_warmup_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        op,
	input  logic [11:0] battery_adc,
	input  logic [11:0] ur_adc,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [7:0]  heater_duty,
	output logic [2:0]  phase,
	output logic        finished
);
	import hws_pkg::*;

	// Sequencer state.
	pc_t    pc_q;
	uword_t uword;
	logic   cond_hit;
	logic   req_acc;
	logic   out_busy;

	// Latched request fields.
	logic        op_q;
	logic [11:0] bat_in_q;
	logic [11:0] ur_q;

	// Configuration and sequence state.
	logic [11:0] ur_limit_q;
	logic [2:0]  phase_q;
	logic [3:0]  tick_q;
	logic [7:0]  tenths_q;
	logic [11:0] battery_q;
	logic [7:0]  duty_q;
	logic        fin_q;

	// Divider datapath.
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsr_q;
	logic [QUO_W-1:0] quo_q;
	logic [3:0]       cnt_q;
	logic [DEN_W-1:0] den;
	logic [8:0]       ramp_next;

	// Output register.
	logic       rsp_valid_q;
	logic [7:0] rsp_duty_q;
	logic [2:0] rsp_phase_q;
	logic       rsp_fin_q;

	hws_ucode_rom u_rom (
		.pc    (pc_q),
		.uword (uword)
	);

	// The only step that takes a request is the wait step at the head of the
	// program, so ready simply follows its control word.
	assign req_ready = (uword.act == ACT_LATCH);
	assign req_acc   = req_valid && req_ready;
	assign out_busy  = rsp_valid_q && !rsp_ready;
	assign ramp_next = {1'b0, tenths_q} + {1'b0, RAMP_STEP_TENTHS};
	assign den       = DEN_W'(battery_q) * DEN_K;

	always_comb begin
		case (uword.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_NO_REQ:   cond_hit = !req_valid;
			C_START:    cond_hit = !op_q;
			C_PH_COND:  cond_hit = (phase_q == PH_COND);
			C_PH_RAMP:  cond_hit = (phase_q == PH_RAMP);
			C_PH_WAIT:  cond_hit = (phase_q == PH_WAIT);
			C_TICK_LT:  cond_hit = (tick_q < CONDENSE_TICKS);
			C_RAMP_END: cond_hit = (ramp_next >= RAMP_END_TENTHS);
			C_UR_ABOVE: cond_hit = (ur_q > ur_limit_q);
			C_DIV_MORE: cond_hit = (cnt_q != 4'd0);
			C_OUT_BUSY: cond_hit = out_busy;
			default:    cond_hit = 1'b0;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ADDR_WAIT_REQ;
		end else if (cond_hit) begin
			pc_q <= uword.target;
		end else begin
			pc_q <= pc_q + pc_t'(1);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ur_limit_q <= '0;
		end else if (cfg_wr_en) begin
			ur_limit_q <= cfg_wr_data;
		end
	end

	// Request capture; payload only, no reset needed.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q     <= op;
			bat_in_q <= battery_adc;
			ur_q     <= ur_adc;
		end
	end

	// Sequence state, driven by the action field of each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			tenths_q  <= '0;
			battery_q <= '0;
			duty_q    <= '0;
			fin_q     <= 1'b0;
		end else begin
			case (uword.act)
				ACT_LATCH: begin
					if (req_acc) begin
						fin_q <= 1'b0;
					end
				end
				ACT_START: begin
					battery_q <= bat_in_q;
					phase_q   <= PH_COND;
					tick_q    <= '0;
					tenths_q  <= COND_TENTHS;
				end
				ACT_TICK: begin
					tick_q <= tick_q + 4'd1;
				end
				ACT_RAMP_ENTER: begin
					phase_q  <= PH_RAMP;
					tenths_q <= RAMP_FIRST_TENTHS;
				end
				ACT_RAMP_STEP: begin
					tenths_q <= ramp_next[7:0];
				end
				ACT_SET_WAIT: begin
					phase_q <= PH_WAIT;
				end
				ACT_SET_DONE: begin
					phase_q <= PH_DONE;
					duty_q  <= '0;
					fin_q   <= 1'b1;
				end
				ACT_DUTY: begin
					// A set top quotient bit means the true quotient is 256 or
					// more, which saturates; a zero battery sample does too.
					if (battery_q == 12'd0 || quo_q[QUO_W-1]) begin
						duty_q <= 8'hFF;
					end else begin
						duty_q <= quo_q[7:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Restoring divider: one quotient bit per step, most significant first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (uword.act == ACT_MUL) begin
			cnt_q <= DIV_LAST_BIT;
		end else if (uword.act == ACT_DIV && cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (uword.act == ACT_MUL) begin
			rem_q <= NUM_W'(tenths_q) * NUM_K;
			dsr_q <= {den, 8'd0};
			quo_q <= '0;
		end else if (uword.act == ACT_DIV) begin
			if (rem_q >= dsr_q) begin
				rem_q <= rem_q - dsr_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dsr_q <= dsr_q >> 1;
		end
	end

	// Output register; the emit step stalls while it is still occupied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (uword.act == ACT_EMIT && !out_busy) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uword.act == ACT_EMIT && !out_busy) begin
			rsp_duty_q  <= duty_q;
			rsp_phase_q <= phase_q;
			rsp_fin_q   <= fin_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign heater_duty = rsp_duty_q;
	assign phase       = rsp_phase_q;
	assign finished    = rsp_fin_q;

endmodule

>>> hdl/hws_checker.sv
// ----------------------------------------------------------------------------
// Heater warm-up sequencer checker
// Port-level assertions, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module hws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] heater_duty,
	input logic [2:0] phase,
	input logic       finished
);
	import hws_pkg::*;

	// A finished response always reports the done phase with the heater off.
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && finished |-> phase == PH_DONE && heater_duty == 8'd0)
		else $error("finished response without done phase and zero duty");

	// Before any start the heater is never driven and nothing finishes.
	a_idle_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && phase == PH_IDLE |-> heater_duty == 8'd0 && !finished)
		else $error("idle response with heater duty or finished flag");

	// One request at a time: the block is busy right after taking one.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in progress");

	// A stalled response holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(heater_duty)
			&& $stable(phase) && $stable(finished))
		else $error("response dropped or changed while stalled");

endmodule

bind heater_warmup_sequencer hws_checker u_hws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.heater_duty (heater_duty),
	.phase       (phase),
	.finished    (finished)
);
